### design/chained_hash_map_insert_lookup_core_macros.svh
// Assertion macros for the checker file chm_checker.sv.
`ifndef CHAINED_HASH_MAP_INSERT_LOOKUP_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_INSERT_LOOKUP_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHM_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequence is checked on the next clock edge.
`define CHM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

### design/chm_pkg.sv
//==============================================================================
// chm_pkg
// Types and constants shared by the chained hash map core.
//==============================================================================
`default_nettype none
package chm_pkg;
    localparam int unsigned POOL_ENTRIES_DEF = 256;
    localparam int unsigned BUCKETS_DEF      = 256;
    localparam int unsigned CFG_W            = 9;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_NEW  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [31:0] key;
        logic [7:0]  pack_ref;
        logic [15:0] asset_ref;
        logic [15:0] piece_ref;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_index;
        logic [7:0]  out_pack;
        logic [15:0] out_asset;
        logic [15:0] out_piece;
    } out_word_t;
endpackage
`default_nettype wire

### design/chained_hash_map_insert_lookup_core.sv
// Front: serial remainder unit, one key bit at a time, then a two-entry queue.
// Back: B_HEAD, B_CMP/B_READ per entry, B_WRT unless hit, then B_OUT (registered).
// The front takes a new word only after the last one is pushed into the queue.
// Reset (aresetn, synchronous): all chains empty, pool free, bucket_count BUCKETS.
`default_nettype none
module chained_hash_map_insert_lookup_core #(
    parameter int unsigned POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
    parameter int unsigned BUCKETS      = chm_pkg::BUCKETS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [1:0]              paddr,
    input  wire [31:0]             pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire chm_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output chm_pkg::out_word_t     m_data
);
    import chm_pkg::*;

    localparam int unsigned BW = $clog2(BUCKETS + 1);

    logic [CFG_W-1:0] bcount_reg;
    logic             q_valid, q_ready;
    in_word_t         q_data;
    logic [BW-1:0]    q_bucket;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == REG_BUCKET_COUNT) ? 32'(bcount_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcount_reg <= CFG_W'(BUCKETS);
        end else if (psel && penable && pwrite && paddr[1] == REG_BUCKET_COUNT) begin
            bcount_reg <= pwdata[CFG_W-1:0];
        end
    end

    chm_front #(.BUCKETS(BUCKETS)) u_front (
        .aclk, .aresetn, .bucket_count(bcount_reg),
        .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data, .q_bucket
    );

    chm_back #(.POOL_ENTRIES(POOL_ENTRIES), .BUCKETS(BUCKETS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .q_bucket,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

### design/chm_front.sv
//==============================================================================
// chm_front
// Accepts words, reduces the key to a bucket index one quotient bit per
// cycle, and pushes the classified word into a two-entry queue.
//==============================================================================
`default_nettype none
module chm_front #(
    parameter int unsigned BUCKETS = 256
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire [chm_pkg::CFG_W-1:0] bucket_count,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire chm_pkg::in_word_t s_data,
    output logic                  q_valid,
    input  wire                   q_ready,
    output chm_pkg::in_word_t     q_data,
    output logic [$clog2(BUCKETS+1)-1:0] q_bucket
);
    import chm_pkg::*;

    localparam int unsigned BW = $clog2(BUCKETS + 1);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_DIV  = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    in_word_t          word_reg;
    logic [BW-1:0]     div_reg;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [5:0]        bit_reg;
    logic [BW:0]       shifted;

    in_word_t          qd_reg [2];
    logic [BW-1:0]     qb_reg [2];
    logic [1:0]        cnt_reg;
    logic              rd_reg, wr_reg;
    logic              push, pop;

    // Clamp the configured count into 1..BUCKETS.
    logic [BW-1:0]     div_clamped;
    always_comb begin
        if (bucket_count == '0) begin
            div_clamped = BW'(1);
        end else if ({{(32-CFG_W){1'b0}}, bucket_count} > 32'(BUCKETS)) begin
            div_clamped = BW'(BUCKETS);
        end else begin
            div_clamped = BW'(bucket_count);
        end
    end

    // bit_reg counts 32..1 while dividing, so the key bit taken is one below it.
    assign shifted = {rem_reg, word_reg.key[5'(bit_reg - 6'd1)]};
    always_comb begin
        if (shifted >= {1'b0, div_reg}) begin
            rem_next = BW'(shifted - {1'b0, div_reg});
        end else begin
            rem_next = shifted[BW-1:0];
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign push    = (state_reg == F_DIV) && (bit_reg == 6'd0) && (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = qd_reg[rd_reg];
    assign q_bucket = qb_reg[rd_reg];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_valid) state_next = F_DIV;
            F_DIV:  if (push) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
            div_reg  <= div_clamped;
            rem_reg  <= '0;
            bit_reg  <= 6'd32;
        end else if (state_reg == F_DIV && bit_reg != 6'd0) begin
            bit_reg  <= bit_reg - 6'd1;
            rem_reg  <= rem_next;
        end
        if (push) begin
            qd_reg[wr_reg] <= word_reg;
            qb_reg[wr_reg] <= rem_reg;
        end
    end
endmodule
`default_nettype wire

### design/chm_back.sv
//==============================================================================
// chm_back
// Walks a bucket chain, reports hit, miss or full, and inserts new entries.
//==============================================================================
`default_nettype none
module chm_back #(
    parameter int unsigned POOL_ENTRIES = 256,
    parameter int unsigned BUCKETS      = 256
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   q_valid,
    output logic                  q_ready,
    input  wire chm_pkg::in_word_t q_data,
    input  wire [$clog2(BUCKETS+1)-1:0] q_bucket,
    output logic                  m_valid,
    input  wire                   m_ready,
    output chm_pkg::out_word_t    m_data
);
    import chm_pkg::*;

    localparam int unsigned PW = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned IW = $clog2(POOL_ENTRIES);
    localparam int unsigned BW = $clog2(BUCKETS + 1);
    localparam int unsigned BI = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [PW-1:0] EMPTY = PW'(POOL_ENTRIES);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_HEAD = 6'b000010,
        B_READ = 6'b000100,
        B_CMP  = 6'b001000,
        B_WRT  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  pack;
        logic [15:0] asset;
        logic [15:0] piece;
        logic [PW-1:0] link;
    } entry_t;

    entry_t         ent_mem [POOL_ENTRIES];
    logic [PW-1:0]  head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;

    bstate_t        state_reg;
    in_word_t       word_reg;
    logic [BI-1:0]  bkt_reg;
    logic [PW-1:0]  cur_reg, tail_reg, used_reg;
    logic [PW:0]    steps_reg;
    logic [PW-1:0]  head_rd_reg;
    entry_t         ent_rd_reg;
    out_word_t      res_reg;
    out_word_t      out_reg;
    logic           out_vld_reg;
    logic [IW-1:0]  new_idx;

    assign new_idx = IW'(PW'(POOL_ENTRIES - 1) - used_reg);
    assign q_ready = (state_reg == B_IDLE);
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == B_HEAD) begin
            head_rd_reg <= head_vld_reg[bkt_reg] ? head_mem[bkt_reg] : EMPTY;
        end
        if (state_reg == B_READ) begin
            ent_rd_reg <= ent_mem[cur_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            head_vld_reg <= '0;
            used_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            // The result word is loaded in B_OUT and held until it is taken.
            out_vld_reg <= (state_reg == B_OUT) || (out_vld_reg && !m_ready);
            unique case (state_reg)
                B_IDLE: if (q_valid) begin
                    word_reg  <= q_data;
                    bkt_reg   <= BI'(q_bucket);
                    tail_reg  <= EMPTY;
                    steps_reg <= '0;
                    state_reg <= B_HEAD;
                end
                B_HEAD: state_reg <= B_CMP;
                B_CMP: begin
                    // First pass uses the head, later passes the entry link.
                    cur_reg   <= (steps_reg == '0) ? head_rd_reg : ent_rd_reg.link;
                    state_reg <= B_READ;
                    if (steps_reg != '0) begin
                        if (ent_rd_reg.key == word_reg.key) begin
                            res_reg   <= '{ST_HIT, 8'(cur_reg), ent_rd_reg.pack,
                                           ent_rd_reg.asset, ent_rd_reg.piece};
                            state_reg <= B_OUT;
                        end else begin
                            tail_reg <= cur_reg;
                        end
                    end
                    if ((steps_reg == '0 && head_rd_reg >= EMPTY) ||
                        (steps_reg != '0 && ent_rd_reg.key != word_reg.key &&
                         (ent_rd_reg.link >= EMPTY ||
                          steps_reg >= (PW+1)'(POOL_ENTRIES)))) begin
                        state_reg <= B_WRT;
                    end
                end
                B_READ: begin
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= B_CMP;
                end
                B_WRT: begin
                    state_reg <= B_OUT;
                    if (!word_reg.mode) begin
                        res_reg <= '{ST_MISS, 8'd0, 8'd0, 16'd0, 16'd0};
                    end else if (used_reg >= EMPTY) begin
                        res_reg <= '{ST_FULL, 8'd0, 8'd0, 16'd0, 16'd0};
                    end else begin
                        res_reg  <= '{ST_NEW, 8'(new_idx), word_reg.pack_ref,
                                      word_reg.asset_ref, word_reg.piece_ref};
                        used_reg <= used_reg + 1'b1;
                        if (tail_reg >= EMPTY) head_vld_reg[bkt_reg] <= 1'b1;
                    end
                end
                B_OUT: if (!out_vld_reg || m_ready) begin
                    out_reg   <= res_reg;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Memory writes: the new entry and, in the same cycle, either the head or the tail link.
    always_ff @(posedge aclk) begin
        if (state_reg == B_WRT && word_reg.mode && used_reg < EMPTY) begin
            ent_mem[new_idx] <= '{word_reg.key, word_reg.pack_ref, word_reg.asset_ref,
                                  word_reg.piece_ref, EMPTY};
            if (tail_reg >= EMPTY) begin
                head_mem[bkt_reg] <= PW'(new_idx);
            end else begin
                ent_mem[tail_reg[IW-1:0]].link <= PW'(new_idx);
            end
        end
    end
endmodule
`default_nettype wire

### design/chm_checker.sv
//==============================================================================
// chm_checker
// Port-level checks for the chained hash map core.
//==============================================================================
`default_nettype none
`include "chained_hash_map_insert_lookup_core_macros.svh"
module chm_checker (
    input wire                     aclk,
    input wire                     aresetn,
    input wire                     s_valid,
    input wire                     s_ready,
    input wire                     m_valid,
    input wire                     m_ready,
    input wire chm_pkg::out_word_t m_data
);
    import chm_pkg::*;

    `CHM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word dropped while stalled")
    `CHM_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && (m_data.status == ST_MISS || m_data.status == ST_FULL), m_data.entry_index == 8'd0 && m_data.out_pack == 8'd0, "miss or full carries data")
    `CHM_ASSERT_NEXT(a_s_gap, aclk, aresetn, s_valid && s_ready, !s_ready, "front took two words back to back")
endmodule
bind chained_hash_map_insert_lookup_core chm_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
`default_nettype wire

### bench/chained_hash_map_insert_lookup_core_tb.sv
//==============================================================================
// Chained hash map core testbench
// Drives lookups and inserts through the word channel, writes the bucket count
// over the register port between phases, and checks every result word against
// a behavioral hash map kept inside the bench.
//==============================================================================
`default_nettype none

class hash_map_scoreboard;
    localparam int unsigned POOL = 256;
    localparam int unsigned EMPTY = 256;

    int unsigned bucket_count;
    int unsigned head [256];
    logic [31:0] ent_key [256];
    logic [7:0]  ent_pack [256];
    logic [15:0] ent_asset [256];
    logic [15:0] ent_piece [256];
    int unsigned ent_link [256];
    int unsigned used;
    chm_pkg::out_word_t pending [$];
    int errors;

    function new();
        bucket_count = 256;
        foreach (head[i]) head[i] = EMPTY;
        used = 0;
        errors = 0;
    endfunction

    function void set_buckets(int unsigned v);
        bucket_count = v & 9'h1ff;
    endfunction

    // Works out the result of one accepted word and updates the map.
    function void note_input(chm_pkg::in_word_t w);
        chm_pkg::out_word_t r;
        int unsigned n, b, cur, last, idx, steps;
        int unsigned found;
        n = bucket_count;
        if (n == 0) n = 1;
        if (n > 256) n = 256;
        b = w.key % n;
        cur = head[b];
        last = EMPTY;
        found = EMPTY;
        for (steps = 0; steps < POOL; steps++) begin
            if (cur >= POOL) break;
            if (ent_key[cur] == w.key) begin
                found = cur;
                break;
            end
            last = cur;
            cur = ent_link[cur];
        end
        r = '0;
        if (found != EMPTY) begin
            r.status = chm_pkg::ST_HIT;
            idx = found;
        end else if (w.mode == 1'b0) begin
            r.status = chm_pkg::ST_MISS;
            idx = EMPTY;
        end else if (used >= POOL) begin
            r.status = chm_pkg::ST_FULL;
            idx = EMPTY;
        end else begin
            idx = POOL - 1 - used;
            ent_key[idx] = w.key;
            ent_pack[idx] = w.pack_ref;
            ent_asset[idx] = w.asset_ref;
            ent_piece[idx] = w.piece_ref;
            ent_link[idx] = EMPTY;
            if (last >= POOL) head[b] = idx;
            else ent_link[last] = idx;
            used++;
            r.status = chm_pkg::ST_NEW;
        end
        if (idx < POOL) begin
            r.entry_index = idx[7:0];
            r.out_pack = ent_pack[idx];
            r.out_asset = ent_asset[idx];
            r.out_piece = ent_piece[idx];
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task check_result(chm_pkg::out_word_t g);
        chm_pkg::out_word_t e;
        if (pending.size() == 0) begin
            report("unexpected word", 32'(g.status), 0);
            return;
        end
        e = pending.pop_front();
        if (g.status != e.status) report("status", g.status, e.status);
        if (g.entry_index != e.entry_index) report("entry_index", g.entry_index, e.entry_index);
        if (g.out_pack != e.out_pack) report("out_pack", g.out_pack, e.out_pack);
        if (g.out_asset != e.out_asset) report("out_asset", g.out_asset, e.out_asset);
        if (g.out_piece != e.out_piece) report("out_piece", g.out_piece, e.out_piece);
    endtask
endclass

module chained_hash_map_insert_lookup_core_tb;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    chm_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    chm_pkg::out_word_t m_data;

    hash_map_scoreboard map_model = new();
    bit hold_off = 1'b0;
    logic [31:0] used_keys [$];

    chained_hash_map_insert_lookup_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic write_buckets(int unsigned v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {chm_pkg::REG_BUCKET_COUNT, 1'b0};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        map_model.set_buckets(v);
    endtask

    // Valid stays high after an accept when the next word follows at once.
    task automatic send_word(chm_pkg::in_word_t w, bit burst);
        int unsigned g;
        g = burst ? 0 : gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        map_model.note_input(w);
        if (w.mode) used_keys.push_back(w.key);
    endtask

    function automatic chm_pkg::in_word_t rand_word(bit ins);
        chm_pkg::in_word_t w;
        w.mode = ins;
        case ($urandom_range(0, 3))
            0: w.key = $urandom;
            1: w.key = $urandom_range(0, 600);
            default: w.key = (used_keys.size() > 0) ?
                used_keys[$urandom_range(0, used_keys.size() - 1)] : $urandom;
        endcase
        w.pack_ref = $urandom;
        w.asset_ref = $urandom;
        w.piece_ref = $urandom;
        return w;
    endfunction

    task automatic drain();
        int unsigned t;
        t = 0;
        s_valid <= 1'b0;
        while (map_model.pending.size() != 0 && t < 200_000) begin
            @(posedge aclk);
            t++;
        end
        repeat (400) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) map_model.check_result(m_data);
            if (hold_off) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        chm_pkg::in_word_t w;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of fields, hit, miss, new, chain at one bucket.
        w = '0; w.mode = 1'b0; w.key = 32'h0;
        send_word(w, 0);
        w = '{1'b1, 32'hffff_ffff, 8'hff, 16'hffff, 16'hffff}; send_word(w, 0);
        w = '{1'b0, 32'hffff_ffff, 8'h00, 16'h0000, 16'h0000}; send_word(w, 0);
        w = '{1'b1, 32'hffff_ffff, 8'h12, 16'h3456, 16'h789a}; send_word(w, 0);
        w = '{1'b1, 32'h0, 8'h00, 16'h0000, 16'h0000}; send_word(w, 0);
        w = '{1'b1, 32'd256, 8'h5a, 16'ha5a5, 16'h5a5a}; send_word(w, 0);
        w = '{1'b1, 32'd512, 8'ha5, 16'h5a5a, 16'ha5a5}; send_word(w, 0);
        w = '{1'b0, 32'd512, 8'h00, 16'h0000, 16'h0000}; send_word(w, 0);
        w = '{1'b0, 32'd768, 8'h00, 16'h0000, 16'h0000}; send_word(w, 0);
        drain();

        // Bucket count of one: every key shares one chain.
        write_buckets(1);
        for (int i = 0; i < 8; i++) send_word(rand_word($urandom_range(0, 1)), 0);
        drain();
        // Out of range values: zero and above the bucket count limit.
        write_buckets(0);
        for (int i = 0; i < 4; i++) send_word(rand_word(1), 0);
        drain();
        write_buckets(511);
        for (int i = 0; i < 4; i++) send_word(rand_word($urandom_range(0, 1)), 0);
        drain();

        // Long hold-off on the result side while the sender keeps going.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 10; i++) send_word(rand_word($urandom_range(0, 1)), 1);
                s_valid <= 1'b0;
            end
        join
        drain();

        // Random phases over several bucket counts; the pool fills toward the end.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: write_buckets(256);
                1: write_buckets($urandom_range(2, 17));
                2: write_buckets($urandom_range(1, 255));
                3: write_buckets(1);
                default: write_buckets(256);
            endcase
            for (int i = 0; i < 130; i++)
                send_word(rand_word($urandom_range(0, 4) != 0), 0);
            drain();
        end
        // Pool full: insert random keys, fresh or already in the map.
        for (int i = 0; i < 20; i++) send_word(rand_word(1), 0);
        drain();

        if (map_model.errors == 0 && map_model.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
+incdir+design
design/chm_pkg.sv
design/chm_front.sv
design/chm_back.sv
design/chained_hash_map_insert_lookup_core.sv
design/chm_checker.sv
bench/chained_hash_map_insert_lookup_core_tb.sv
